### hw/rtl/tccf_pkg.sv
package tccf_pkg;

    // CORDIC iteration count, bounded by the length of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int ITER_W       = 5;

    // datapath widths
    localparam int CW        = 52;  // CORDIC x/y
    localparam int ZW        = 26;  // CORDIC angle, 1/256 cdeg
    localparam int ACC_W     = 64;  // serial multiplier accumulator
    localparam int MPL_W     = 32;  // serial multiplier operand
    localparam int MUL_CNT_W = 6;
    localparam int DIV_W     = 19;
    localparam int DIV_CNT_W = 5;

    localparam logic [15:0] GYRO_WEIGHT_RESET = 16'd62259;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] magnet_x;
        logic signed [15:0] magnet_y;
        logic signed [15:0] magnet_z;
        logic        [15:0] elapsed_ms;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] heading_angle;
    } result_t;

    typedef struct packed {
        logic                 start;
        logic                 load;
        logic                 neg;
        logic [MUL_CNT_W-1:0] nbits;
    } mul_cmd_t;

    typedef enum logic {
        CM_ATAN,
        CM_SINCOS
    } cordic_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_ATAN_P,
        OP_ATAN_R,
        OP_ADV_P,
        OP_MIX_P1,
        OP_MIX_P2,
        OP_DIV_P,
        OP_ADV_R,
        OP_MIX_R1,
        OP_MIX_R2,
        OP_DIV_R,
        OP_SC_P,
        OP_SC_R,
        OP_SRSP,
        OP_CRSP,
        OP_XM1,
        OP_XM2,
        OP_XM3,
        OP_YM1,
        OP_YM2,
        OP_HEAD
    } op_t;

    // arctan(2^-i) in 1/256 centidegree
    function automatic logic [20:0] atan_entry(input logic [ITER_W-1:0] i);
        logic [20:0] v;
        case (i)
            5'd0:    v = 21'd1152000;
            5'd1:    v = 21'd680065;
            5'd2:    v = 21'd359328;
            5'd3:    v = 21'd182400;
            5'd4:    v = 21'd91554;
            5'd5:    v = 21'd45822;
            5'd6:    v = 21'd22916;
            5'd7:    v = 21'd11459;
            5'd8:    v = 21'd5730;
            5'd9:    v = 21'd2865;
            5'd10:   v = 21'd1432;
            5'd11:   v = 21'd716;
            5'd12:   v = 21'd358;
            5'd13:   v = 21'd179;
            5'd14:   v = 21'd90;
            5'd15:   v = 21'd45;
            5'd16:   v = 21'd22;
            5'd17:   v = 21'd11;
            5'd18:   v = 21'd6;
            5'd19:   v = 21'd3;
            5'd20:   v = 21'd1;
            5'd21:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/tccf_mul.sv
// Bit-serial multiply-accumulate: one multiplier bit per cycle, LSB first.
module tccf_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tccf_pkg::mul_cmd_t                   cmd,
    input  logic signed [tccf_pkg::ACC_W-1:0]    init,
    input  logic signed [tccf_pkg::ACC_W-1:0]    mcand,
    input  logic        [tccf_pkg::MPL_W-1:0]    mplier,
    output logic                                 done,
    output logic signed [tccf_pkg::ACC_W-1:0]    acc
);
    import tccf_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;
    logic [MUL_CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] a_reg, a_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [MPL_W-1:0]        b_reg, b_next;
    logic                    last;
    logic                    sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        last      = (cnt_reg == MUL_CNT_W'(1));
        // top bit of the operand carries negative weight; neg negates every term
        sub       = last ^ neg_reg;
        if (cmd.start)
        begin
            a_next    = mcand;
            b_next    = mplier;
            cnt_next  = cmd.nbits;
            neg_next  = cmd.neg;
            busy_next = 1'b1;
            if (cmd.load)
            begin
                acc_next = init;
            end
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = sub ? (acc_reg - a_reg) : (acc_reg + a_reg);
            end
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - MUL_CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

### hw/rtl/tccf_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle: vectoring (atan2) or rotation (sin/cos).
module tccf_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tccf_pkg::cordic_cmd_t             cmd,
    input  logic signed [tccf_pkg::CW-1:0]    x_in,
    input  logic signed [tccf_pkg::CW-1:0]    y_in,
    input  logic signed [15:0]                ang_in,
    output logic                              done,
    output logic signed [15:0]                atan_out,
    output logic signed [31:0]                sin_out,
    output logic signed [31:0]                cos_out
);
    import tccf_pkg::*;

    localparam logic signed [17:0] A180  = 18'sd18000;
    localparam logic signed [17:0] A90   = 18'sd9000;
    localparam logic signed [17:0] A360  = 18'sd36000;
    localparam logic signed [ZW-1:0] Z180 = ZW'(4608000);
    localparam logic signed [ZW-1:0] ZLIM = ZW'(18000);
    localparam logic signed [CW-1:0] GAIN = CW'(652032874);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ITER_W-1:0]    cnt_reg, cnt_next;
    cordic_mode_t         mode_reg, mode_next;
    logic                 zero_reg, zero_next;
    logic                 flip_reg, flip_next;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    logic signed [17:0]   ang_w;
    logic signed [17:0]   ang_a;
    logic                 flip_s;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] tab;
    logic signed [ZW-1:0] z_rnd;

    always_comb
    begin
        // wrap to +-180, then fold into +-90 with a sign flip
        ang_w  = {{2{ang_in[15]}}, ang_in};
        if (ang_w > A180)
            ang_a = ang_w - A360;
        else if (ang_w < -A180)
            ang_a = ang_w + A360;
        else
            ang_a = ang_w;
        flip_s = 1'b0;
        if (ang_a > A90)
        begin
            ang_a  = ang_a - A180;
            flip_s = 1'b1;
        end
        else if (ang_a < -A90)
        begin
            ang_a  = ang_a + A180;
            flip_s = 1'b1;
        end

        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        tab = ZW'(atan_entry(cnt_reg));

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        zero_next = zero_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mode_next = cmd.mode;
            if (cmd.mode == CM_ATAN)
            begin
                zero_next = (x_in == '0) && (y_in == '0);
                flip_next = 1'b0;
                if (x_in < 0)
                begin
                    x_next = -x_in;
                    y_next = -y_in;
                    z_next = (y_in >= 0) ? Z180 : -Z180;
                end
                else
                begin
                    x_next = x_in;
                    y_next = y_in;
                    z_next = '0;
                end
            end
            else
            begin
                zero_next = 1'b0;
                flip_next = flip_s;
                x_next    = GAIN;
                y_next    = '0;
                z_next    = ZW'(ang_a) <<< 8;
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg == CM_ATAN)
            begin
                if (y_reg >= 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tab;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tab;
                end
            end
            else
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tab;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tab;
                end
            end
            cnt_next = cnt_reg + ITER_W'(1);
            if (cnt_reg == ITER_W'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= CM_ATAN;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // round half up to centidegrees, clamp to +-180
    always_comb
    begin
        z_rnd = (z_reg + ZW'(128)) >>> 8;
        if (zero_reg)
            atan_out = '0;
        else if (z_rnd > ZLIM)
            atan_out = 16'sd18000;
        else if (z_rnd < -ZLIM)
            atan_out = -16'sd18000;
        else
            atan_out = 16'(z_rnd);
    end

    assign sin_out = flip_reg ? 32'(-y_reg) : 32'(y_reg);
    assign cos_out = flip_reg ? 32'(-x_reg) : 32'(x_reg);
    assign done    = done_reg;

endmodule

### hw/rtl/tccf_div5.sv
// Restoring divide by five, one quotient bit per cycle, MSB first.
module tccf_div5 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tccf_pkg::DIV_W-1:0]    value,
    output logic                          done,
    output logic [tccf_pkg::DIV_W-1:0]    quot
);
    import tccf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     num_reg, num_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [2:0]           rem_reg, rem_next;
    logic [3:0]           trial;
    logic                 qbit;

    always_comb
    begin
        trial     = {rem_reg, num_reg[DIV_W-1]};
        qbit      = (trial >= 4'd5);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            num_next  = value;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? 3'(trial - 4'd5) : trial[2:0];
            quot_next = {quot_reg[DIV_W-2:0], qbit};
            num_next  = num_reg << 1;
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### hw/rtl/tilt_compensated_compass_filter.sv
// Tilt-compensated compass with a complementary pitch/roll filter.
// Input channel (sample_valid / sample_stall / sample_word): one IMU word,
// accelerometer, gyro x/y, magnetometer and elapsed milliseconds. A word is
// taken when valid is high and stall low; stall stays high while a word is
// being worked on.
// Output channel (result_valid / result_stall / result_word): filtered pitch,
// roll and heading in centidegrees. The result sits in an output register,
// so the next sample is taken while a result still waits on a stalled
// receiver; the block only holds at its last step if the previous result
// has not yet been taken.
// Steps: each word runs through the shared bit-serial multiplier (one operand
// bit per cycle, thirteen products), five passes of the iterative CORDIC (16
// rotations each) and two serial divide-by-five passes, run in strict
// sequence, each step issued in ST_ISSUE and awaited in ST_WAIT. A new word
// is taken only after the current one has reached the output register.
// Configuration: weight_we / weight_data write the gyro blend weight (Q0.16);
// write only while idle.
// Reset: stored pitch and roll clear to zero, the weight returns to 62259,
// no result is pending.
module tilt_compensated_compass_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  tccf_pkg::sample_t   sample_word,
    output logic                result_valid,
    input  logic                result_stall,
    output tccf_pkg::result_t   result_word,
    input  logic                weight_we,
    input  logic [15:0]         weight_data
);
    import tccf_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF_DIV = ACC_W'(5242880);
    localparam logic signed [ACC_W-1:0] T_LO     = -ACC_W'(163840);
    localparam logic signed [ACC_W-1:0] T_HI     = ACC_W'(163839);
    localparam logic signed [ACC_W-1:0] T_OFS    = ACC_W'(327680);
    localparam logic signed [ACC_W-1:0] RND_Q30  = ACC_W'(64'sd536870912);

    state_t  state_reg, state_next;
    op_t     op_reg, op_next;
    sample_t smp_reg, smp_next;
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;
    logic [15:0] weight_reg, weight_next;

    logic signed [15:0] pitch_reg, pitch_next;
    logic signed [15:0] roll_reg, roll_next;
    logic signed [15:0] pm_reg, pm_next;
    logic signed [15:0] rm_reg, rm_next;
    logic signed [15:0] head_reg, head_next;
    logic signed [31:0] sp_reg, sp_next;
    logic signed [31:0] cp_reg, cp_next;
    logic signed [31:0] sr_reg, sr_next;
    logic signed [31:0] cr_reg, cr_next;
    logic signed [33:0] srsp_reg, srsp_next;
    logic signed [33:0] crsp_reg, crsp_next;
    logic signed [CW-1:0] xm_reg, xm_next;

    // unit hookup
    mul_cmd_t             mul_cmd;
    logic signed [ACC_W-1:0] mul_init;
    logic signed [ACC_W-1:0] mul_mcand;
    logic [MPL_W-1:0]     mul_mplier;
    logic                 mul_done;
    logic signed [ACC_W-1:0] mul_acc;

    cordic_cmd_t          cor_cmd;
    logic signed [CW-1:0] cor_x;
    logic signed [CW-1:0] cor_y;
    logic signed [15:0]   cor_ang;
    logic                 cor_done;
    logic signed [15:0]   cor_atan;
    logic signed [31:0]   cor_sin;
    logic signed [31:0]   cor_cos;

    logic                 div_start;
    logic [DIV_W-1:0]     div_value;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quot;

    logic                 op_done;
    logic                 accept;
    logic                 deliver;
    logic signed [ACC_W-1:0] blend_t;
    logic signed [ACC_W-1:0] blend_sat;
    logic signed [15:0]   blend_angle;

    tccf_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mul_cmd),
        .init   (mul_init),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .done   (mul_done),
        .acc    (mul_acc)
    );

    tccf_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cor_cmd),
        .x_in     (cor_x),
        .y_in     (cor_y),
        .ang_in   (cor_ang),
        .done     (cor_done),
        .atan_out (cor_atan),
        .sin_out  (cor_sin),
        .cos_out  (cor_cos)
    );

    tccf_div5 u_div5 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .value (div_value),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign deliver      = (state_reg == ST_FINISH) && (!res_valid_reg || !result_stall);

    // which unit finishes the current step
    always_comb
    begin
        case (op_reg)
            OP_ATAN_P, OP_ATAN_R, OP_SC_P, OP_SC_R, OP_HEAD: op_done = cor_done;
            OP_DIV_P, OP_DIV_R:                              op_done = div_done;
            default:                                         op_done = mul_done;
        endcase
    end

    // blend numerator -> floor((n + 5242880) / 10485760), pre-clamped so that the
    // divide-by-five lands inside 16 bits
    always_comb
    begin
        blend_t = (mul_acc + HALF_DIV) >>> 21;
        if (blend_t < T_LO)
            blend_sat = T_LO;
        else if (blend_t > T_HI)
            blend_sat = T_HI;
        else
            blend_sat = blend_t;
        div_value   = DIV_W'(blend_sat + T_OFS);
        blend_angle = 16'(div_quot - DIV_W'(65536));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ISSUE;
                    op_next    = OP_ATAN_P;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (op_done)
                begin
                    if (op_reg == OP_HEAD)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        op_next    = op_t'(op_reg + 5'd1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (deliver)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // unit commands and operand selection
    always_comb
    begin
        mul_cmd    = '0;
        mul_init   = '0;
        mul_mcand  = '0;
        mul_mplier = '0;
        cor_cmd    = '{start: 1'b0, mode: CM_ATAN};
        cor_x      = '0;
        cor_y      = '0;
        cor_ang    = '0;
        div_start  = 1'b0;
        if (state_reg == ST_ISSUE)
        begin
            case (op_reg)
                OP_ATAN_P:
                begin
                    cor_cmd = '{start: 1'b1, mode: CM_ATAN};
                    cor_x   = CW'(smp_reg.accel_z) <<< 16;
                    cor_y   = CW'(smp_reg.accel_x) <<< 16;
                end
                OP_ATAN_R:
                begin
                    cor_cmd = '{start: 1'b1, mode: CM_ATAN};
                    cor_x   = CW'(smp_reg.accel_z) <<< 16;
                    cor_y   = CW'(smp_reg.accel_y) <<< 16;
                end
                OP_ADV_P:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b1, neg: 1'b0, nbits: 6'd16};
                    mul_init   = (ACC_W'(pitch_reg) <<< 7) + (ACC_W'(pitch_reg) <<< 5);
                    mul_mcand  = ACC_W'(smp_reg.elapsed_ms);
                    mul_mplier = MPL_W'(smp_reg.gyro_y);
                end
                OP_ADV_R:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b1, neg: 1'b1, nbits: 6'd16};
                    mul_init   = (ACC_W'(roll_reg) <<< 7) + (ACC_W'(roll_reg) <<< 5);
                    mul_mcand  = ACC_W'(smp_reg.elapsed_ms);
                    mul_mplier = MPL_W'(smp_reg.gyro_x);
                end
                OP_MIX_P1, OP_MIX_R1:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b1, neg: 1'b0, nbits: 6'd17};
                    mul_mcand  = mul_acc;
                    mul_mplier = MPL_W'(weight_reg);
                end
                OP_MIX_P2:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b0, neg: 1'b0, nbits: 6'd18};
                    mul_mcand  = (ACC_W'(pm_reg) <<< 7) + (ACC_W'(pm_reg) <<< 5);
                    mul_mplier = MPL_W'(17'h10000 - {1'b0, weight_reg});
                end
                OP_MIX_R2:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b0, neg: 1'b0, nbits: 6'd18};
                    mul_mcand  = (ACC_W'(rm_reg) <<< 7) + (ACC_W'(rm_reg) <<< 5);
                    mul_mplier = MPL_W'(17'h10000 - {1'b0, weight_reg});
                end
                OP_DIV_P, OP_DIV_R:
                begin
                    div_start = 1'b1;
                end
                OP_SC_P:
                begin
                    cor_cmd = '{start: 1'b1, mode: CM_SINCOS};
                    cor_ang = pitch_reg;
                end
                OP_SC_R:
                begin
                    cor_cmd = '{start: 1'b1, mode: CM_SINCOS};
                    cor_ang = roll_reg;
                end
                OP_SRSP:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b1, neg: 1'b0, nbits: 6'd32};
                    mul_init   = RND_Q30;
                    mul_mcand  = ACC_W'(sr_reg);
                    mul_mplier = MPL_W'(sp_reg);
                end
                OP_CRSP:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b1, neg: 1'b0, nbits: 6'd32};
                    mul_init   = RND_Q30;
                    mul_mcand  = ACC_W'(cr_reg);
                    mul_mplier = MPL_W'(sp_reg);
                end
                OP_XM1:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b1, neg: 1'b0, nbits: 6'd16};
                    mul_mcand  = ACC_W'(cp_reg);
                    mul_mplier = MPL_W'(smp_reg.magnet_x);
                end
                OP_XM2:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b0, neg: 1'b1, nbits: 6'd16};
                    mul_mcand  = ACC_W'(srsp_reg);
                    mul_mplier = MPL_W'(smp_reg.magnet_y);
                end
                OP_XM3:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b0, neg: 1'b0, nbits: 6'd16};
                    mul_mcand  = ACC_W'(crsp_reg);
                    mul_mplier = MPL_W'(smp_reg.magnet_z);
                end
                OP_YM1:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b1, neg: 1'b0, nbits: 6'd16};
                    mul_mcand  = ACC_W'(cr_reg);
                    mul_mplier = MPL_W'(smp_reg.magnet_y);
                end
                OP_YM2:
                begin
                    mul_cmd    = '{start: 1'b1, load: 1'b0, neg: 1'b0, nbits: 6'd16};
                    mul_mcand  = ACC_W'(sr_reg);
                    mul_mplier = MPL_W'(smp_reg.magnet_z);
                end
                OP_HEAD:
                begin
                    cor_cmd = '{start: 1'b1, mode: CM_ATAN};
                    cor_x   = xm_reg;
                    cor_y   = CW'(mul_acc);
                end
                default:
                begin
                    mul_cmd = '0;
                end
            endcase
        end
    end

    // captures at the end of each step
    always_comb
    begin
        smp_next       = smp_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        weight_next    = weight_reg;
        pitch_next     = pitch_reg;
        roll_next      = roll_reg;
        pm_next        = pm_reg;
        rm_next        = rm_reg;
        head_next      = head_reg;
        sp_next        = sp_reg;
        cp_next        = cp_reg;
        sr_next        = sr_reg;
        cr_next        = cr_reg;
        srsp_next      = srsp_reg;
        crsp_next      = crsp_reg;
        xm_next        = xm_reg;

        if (weight_we)
            weight_next = weight_data;
        if (accept)
            smp_next = sample_word;
        if (result_valid && !result_stall)
            res_valid_next = 1'b0;
        if (deliver)
        begin
            res_valid_next = 1'b1;
            res_next       = '{pitch_angle: pitch_reg, roll_angle: roll_reg,
                               heading_angle: head_reg};
        end

        if ((state_reg == ST_WAIT) && op_done)
        begin
            case (op_reg)
                OP_ATAN_P: pm_next    = -cor_atan;
                OP_ATAN_R: rm_next    = -cor_atan;
                OP_DIV_P:  pitch_next = blend_angle;
                OP_DIV_R:  roll_next  = blend_angle;
                OP_SC_P:
                begin
                    sp_next = cor_sin;
                    cp_next = cor_cos;
                end
                OP_SC_R:
                begin
                    sr_next = cor_sin;
                    cr_next = cor_cos;
                end
                OP_SRSP:   srsp_next  = 34'(mul_acc >>> 30);
                OP_CRSP:   crsp_next  = 34'(mul_acc >>> 30);
                OP_XM3:    xm_next    = CW'(mul_acc);
                OP_HEAD:   head_next  = cor_atan;
                default:   xm_next    = xm_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_ATAN_P;
            res_valid_reg <= 1'b0;
            weight_reg    <= GYRO_WEIGHT_RESET;
            pitch_reg     <= '0;
            roll_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            res_valid_reg <= res_valid_next;
            weight_reg    <= weight_next;
            pitch_reg     <= pitch_next;
            roll_reg      <= roll_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        res_reg  <= res_next;
        pm_reg   <= pm_next;
        rm_reg   <= rm_next;
        head_reg <= head_next;
        sp_reg   <= sp_next;
        cp_reg   <= cp_next;
        sr_reg   <= sr_next;
        cr_reg   <= cr_next;
        srsp_reg <= srsp_next;
        crsp_reg <= crsp_next;
        xm_reg   <= xm_next;
    end

    assign result_valid = res_valid_reg;
    assign result_word  = res_reg;

endmodule
